>>> rtl/adcw_pkg.sv
// shared constants, types and helpers for the congestion window block
// no dependencies; every other file imports this package
`timescale 1ns / 1ps

package adcw_pkg;

  localparam int WINDOW_FRAC_BITS = 12;

  localparam int WIN_W  = 24;
  localparam int TIME_W = 32;
  localparam int CFG_W  = 16;
  localparam int LOSS_W = 13;
  localparam int OUT_W  = 12;
  localparam int APB_DW = 32;
  localparam int APB_AW = 4;

  // dividend of the avoidance step is numerator << frac bits
  localparam int DIVD_W = CFG_W + WINDOW_FRAC_BITS;

  localparam logic [WIN_W-1:0]  WIN_ONE   = WIN_W'(64'd1 << WINDOW_FRAC_BITS);
  localparam logic [WIN_W-1:0]  WIN_RESET = WIN_W'(64'd14 << WINDOW_FRAC_BITS);
  localparam logic [WIN_W-1:0]  WIN_MAX   = '1;
  localparam logic [LOSS_W-1:0] LOSS_MAX  = '1;
  localparam logic [OUT_W-1:0]  WHOLE_MAX = '1;

  localparam logic [CFG_W-1:0] TIMEOUT_RESET = CFG_W'(80);
  localparam logic [CFG_W-1:0] SS_STEP_RESET = CFG_W'(8192);
  localparam logic [CFG_W-1:0] AV_NUM_RESET  = CFG_W'(6144);

  typedef enum logic [1:0] {
    REG_TIMEOUT   = 2'd0,
    REG_SS_STEP   = 2'd1,
    REG_AVOID_NUM = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [OUT_W-1:0] whole;
    logic             ss_flag;
    logic             timeout;
    logic             halved;
  } result_t;

  // integer part of the window, clipped to the output width
  function automatic logic [OUT_W-1:0] whole_sat(input logic [WIN_W-1:0] win);
    logic [WIN_W-1:0] w;
    w = win >> WINDOW_FRAC_BITS;
    if (w > WIN_W'(WHOLE_MAX)) begin
      return WHOLE_MAX;
    end
    return w[OUT_W-1:0];
  endfunction

endpackage

>>> rtl/adcw_rtt_serial.sv
// bit-serial round-trip subtract and timeout compare, lsb first
// depends on adcw_pkg
`timescale 1ns / 1ps

module adcw_rtt_serial import adcw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [TIME_W-1:0] sent_time,
  input  logic [TIME_W-1:0] ack_time,
  input  logic [CFG_W-1:0]  limit,
  output logic              done,
  output logic              timeout
);

  localparam int CNT_W = $clog2(TIME_W);

  logic [TIME_W-1:0] sent_r, sent_nxt;
  logic [TIME_W-1:0] ack_r, ack_nxt;
  logic [TIME_W-1:0] lim_r, lim_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              carry_r, carry_nxt;
  logic              gt_r, gt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic              a_bit, nb_bit, d_bit;

  always_comb begin
    a_bit     = ack_r[0];
    nb_bit    = ~sent_r[0];
    d_bit     = a_bit ^ nb_bit ^ carry_r;
    sent_nxt  = sent_r;
    ack_nxt   = ack_r;
    lim_nxt   = lim_r;
    cnt_nxt   = cnt_r;
    carry_nxt = carry_r;
    gt_nxt    = gt_r;
    busy_nxt  = busy_r;
    done_nxt  = done_r;
    if (start) begin
      sent_nxt  = sent_time;
      ack_nxt   = ack_time;
      lim_nxt   = TIME_W'(limit);
      cnt_nxt   = '0;
      carry_nxt = 1'b1;
      gt_nxt    = 1'b0;
      busy_nxt  = 1'b1;
      done_nxt  = 1'b0;
    end else if (busy_r) begin
      sent_nxt  = sent_r >> 1;
      ack_nxt   = ack_r >> 1;
      lim_nxt   = lim_r >> 1;
      cnt_nxt   = cnt_r + 1'b1;
      carry_nxt = (a_bit & nb_bit) | (carry_r & (a_bit ^ nb_bit));
      // a higher differing bit decides the compare
      if (d_bit != lim_r[0]) begin
        gt_nxt = d_bit;
      end
      if (cnt_r == CNT_W'(TIME_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sent_r  <= sent_nxt;
    ack_r   <= ack_nxt;
    lim_r   <= lim_nxt;
    carry_r <= carry_nxt;
    gt_r    <= gt_nxt;
  end

  assign done    = done_r;
  assign timeout = gt_r;

endmodule

>>> rtl/adcw_div_serial.sv
// restoring divider, one quotient bit per cycle, for the avoidance step
// depends on adcw_pkg
`timescale 1ns / 1ps

module adcw_div_serial import adcw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [CFG_W-1:0]  numerator,
  input  logic [WIN_W-1:0]  divisor,
  output logic              done,
  output logic [DIVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVD_W + 1);

  logic [DIVD_W-1:0] dq_r, dq_nxt;
  logic [WIN_W-1:0]  rem_r, rem_nxt;
  logic [WIN_W-1:0]  dvs_r, dvs_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [WIN_W:0]    shifted, diff;
  logic              ge;

  always_comb begin
    shifted  = {rem_r, dq_r[DIVD_W-1]};
    diff     = shifted - {1'b0, dvs_r};
    ge       = shifted >= {1'b0, dvs_r};
    dq_nxt   = dq_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    if (start) begin
      dq_nxt   = {numerator, {WINDOW_FRAC_BITS{1'b0}}};
      rem_nxt  = '0;
      // window is floored at one, zero guarded anyway
      dvs_nxt  = (divisor == '0) ? WIN_W'(1) : divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[WIN_W-1:0] : shifted[WIN_W-1:0];
      dq_nxt  = {dq_r[DIVD_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DIVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = dq_r;

endmodule

>>> rtl/adcw_window.sv
// window state: slow start flag, loss counter, threshold and window update
// depends on adcw_pkg
`timescale 1ns / 1ps

module adcw_window import adcw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              upd,
  input  logic              timeout,
  input  logic [CFG_W-1:0]  ss_step,
  input  logic [DIVD_W-1:0] avoid_inc,
  output logic [WIN_W-1:0]  window,
  output result_t           result
);

  localparam int AV_W  = ((DIVD_W > WIN_W) ? DIVD_W : WIN_W) + 1;
  localparam int CMP_W = LOSS_W + WIN_W;

  logic [WIN_W-1:0]  win_r, win_nxt;
  logic              ss_r, ss_nxt;
  logic [LOSS_W-1:0] lc_r, lc_nxt;
  logic [WIN_W-1:0]  thr_r, thr_nxt;
  logic              halved;
  logic [CMP_W-1:0]  lc_sh;
  logic [AV_W-1:0]   sum;

  always_comb begin
    lc_sh   = CMP_W'(lc_r) << WINDOW_FRAC_BITS;
    win_nxt = win_r;
    ss_nxt  = ss_r;
    lc_nxt  = lc_r;
    thr_nxt = thr_r;
    halved  = 1'b0;
    sum     = '0;
    if (timeout) begin
      ss_nxt = 1'b0;
      if (lc_sh >= CMP_W'(thr_r)) begin
        lc_nxt  = '0;
        thr_nxt = win_r;
        win_nxt = win_r >> 1;
        halved  = 1'b1;
      end else if (lc_r != LOSS_MAX) begin
        lc_nxt = lc_r + 1'b1;
      end
    end else begin
      if (ss_r) begin
        sum = AV_W'(win_r) + AV_W'(ss_step);
      end else begin
        sum = AV_W'(win_r) + AV_W'(avoid_inc);
      end
      win_nxt = (sum > AV_W'(WIN_MAX)) ? WIN_MAX : sum[WIN_W-1:0];
    end
    if (win_nxt < WIN_ONE) begin
      win_nxt = WIN_ONE;
    end
    result.whole   = whole_sat(win_nxt);
    result.ss_flag = ss_nxt;
    result.timeout = timeout;
    result.halved  = halved;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= WIN_RESET;
      ss_r  <= 1'b1;
      lc_r  <= '0;
      thr_r <= '0;
    end else if (upd) begin
      win_r <= win_nxt;
      ss_r  <= ss_nxt;
      lc_r  <= lc_nxt;
      thr_r <= thr_nxt;
    end
  end

  assign window = win_r;

endmodule

>>> rtl/ack_driven_congestion_window.sv
// channel  | direction | transaction contents
// in_      | input     | sent_time_ms, ack_time_ms (32 bit each)
// out_     | output    | window_datagrams (12), in_slow_start, timeout_seen, window_halved
// cfg_     | apb slave | timeout_limit_ms @0, slow_start_step @4, avoidance_numerator @8
//
// one acknowledgement runs from acceptance through the bit-serial round-trip
// subtract/compare (the avoidance divider runs alongside it), then through the
// update that loads the result.
// a new transaction is accepted the cycle after the result is loaded, even if
// the result is still stalled; an update waits while the output register is full
// and stalled.
// synchronous active-low reset restores window 14.0, slow start and reset registers.
// depends on adcw_pkg, adcw_rtt_serial, adcw_div_serial, adcw_window
`timescale 1ns / 1ps

module ack_driven_congestion_window import adcw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [TIME_W-1:0] in_sent_time_ms,
  input  logic [TIME_W-1:0] in_ack_time_ms,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [OUT_W-1:0]  out_window_datagrams,
  output logic              out_in_slow_start,
  output logic              out_timeout_seen,
  output logic              out_window_halved,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [APB_AW-1:0] cfg_paddr,
  input  logic [APB_DW-1:0] cfg_pwdata,
  output logic [APB_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t            state_r, state_nxt;
  logic [CFG_W-1:0]  tmo_r, ss_step_r, av_num_r;
  logic              out_valid_r, out_valid_nxt;
  result_t           out_r;
  result_t           res;
  logic              accept, upd, cfg_wr;
  logic              rtt_done, timeout, div_done;
  logic [DIVD_W-1:0] quot;
  logic [WIN_W-1:0]  window;
  reg_idx_t          reg_idx;

  assign accept = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign upd = (state_r == ST_RUN) && rtt_done && div_done && (!out_valid_r || !out_stall);

  adcw_rtt_serial u_rtt (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (accept),
    .sent_time (in_sent_time_ms),
    .ack_time  (in_ack_time_ms),
    .limit     (tmo_r),
    .done      (rtt_done),
    .timeout   (timeout)
  );

  adcw_div_serial u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (accept),
    .numerator (av_num_r),
    .divisor   (window),
    .done      (div_done),
    .quotient  (quot)
  );

  adcw_window u_win (
    .clk       (clk),
    .rst_n     (rst_n),
    .upd       (upd),
    .timeout   (timeout),
    .ss_step   (ss_step_r),
    .avoid_inc (quot),
    .window    (window),
    .result    (res)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (upd) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    out_valid_nxt = out_valid_r;
    if (upd) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      out_r <= res;
    end
  end

  // apb register file
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign reg_idx    = reg_idx_t'(cfg_paddr[APB_AW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tmo_r     <= TIMEOUT_RESET;
      ss_step_r <= SS_STEP_RESET;
      av_num_r  <= AV_NUM_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_TIMEOUT:   tmo_r     <= cfg_pwdata[CFG_W-1:0];
        REG_SS_STEP:   ss_step_r <= cfg_pwdata[CFG_W-1:0];
        REG_AVOID_NUM: av_num_r  <= cfg_pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TIMEOUT:   cfg_prdata = APB_DW'(tmo_r);
      REG_SS_STEP:   cfg_prdata = APB_DW'(ss_step_r);
      REG_AVOID_NUM: cfg_prdata = APB_DW'(av_num_r);
      default:       cfg_prdata = '0;
    endcase
  end

  assign out_valid            = out_valid_r;
  assign out_window_datagrams = out_r.whole;
  assign out_in_slow_start    = out_r.ss_flag;
  assign out_timeout_seen     = out_r.timeout;
  assign out_window_halved    = out_r.halved;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall && !rtt_done)
    else $error("engine not busy after accepted transaction");

  a_update_both_done: assert property (@(posedge clk) disable iff (!rst_n)
    upd |-> $past(state_r) == ST_RUN && div_done)
    else $error("update without finished divider");

  a_window_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_window_datagrams != '0)
    else $error("window below one datagram");

  a_halve_on_timeout: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_window_halved |-> out_timeout_seen && !out_in_slow_start)
    else $error("window halved without timeout");

endmodule

>>> bench/adcw_checker.sv
`timescale 1ns / 1ps
// checker for ack_driven_congestion_window: keeps its own window state, predicts the
// result of every accepted ack and compares result and register read transactions
// depends on adcw_pkg
module adcw_checker import adcw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [TIME_W-1:0] in_sent_time_ms,
  input  logic [TIME_W-1:0] in_ack_time_ms,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [OUT_W-1:0]  out_window_datagrams,
  input  logic              out_in_slow_start,
  input  logic              out_timeout_seen,
  input  logic              out_window_halved,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [APB_AW-1:0] cfg_paddr,
  input  logic [APB_DW-1:0] cfg_pwdata,
  input  logic [APB_DW-1:0] cfg_prdata,
  input  logic              cfg_pready,
  output int                fail_count,
  output int                pending
);

  logic [CFG_W-1:0]  rtt_limit;
  logic [CFG_W-1:0]  ss_step;
  logic [CFG_W-1:0]  avoid_num;
  logic [WIN_W-1:0]  window;
  logic [WIN_W-1:0]  loss_thresh;
  logic [LOSS_W-1:0] loss_cnt;
  logic              ss_on;
  result_t           window_updates[$];
  int                mismatches = 0;

  task automatic report_mismatch(input string msg);
    if (mismatches < 100) begin
      $display("%0t mismatch: %s", $time, msg);
    end
    mismatches++;
  endtask

  // one ack through the window update, state advanced in place
  function automatic result_t advance_window(input logic [TIME_W-1:0] sent,
                                             input logic [TIME_W-1:0] ack);
    logic [TIME_W-1:0] rtt;
    logic [63:0]       grown;
    logic [63:0]       divisor;
    logic [WIN_W-1:0]  whole;
    result_t           r;
    rtt = ack - sent;
    r.timeout = rtt > TIME_W'(rtt_limit);
    r.halved = 1'b0;
    if (r.timeout) begin
      ss_on = 1'b0;
      if ((64'(loss_cnt) << WINDOW_FRAC_BITS) >= 64'(loss_thresh)) begin
        loss_cnt = '0;
        loss_thresh = window;
        window = window >> 1;
        r.halved = 1'b1;
      end else if (loss_cnt != LOSS_MAX) begin
        loss_cnt = loss_cnt + 1'b1;
      end
    end else begin
      if (ss_on) begin
        grown = 64'(window) + 64'(ss_step);
      end else begin
        divisor = (window == '0) ? 64'd1 : 64'(window);
        grown = 64'(window) + ((64'(avoid_num) << WINDOW_FRAC_BITS) / divisor);
      end
      window = (grown > 64'(WIN_MAX)) ? WIN_MAX : grown[WIN_W-1:0];
    end
    if (window < WIN_ONE) begin
      window = WIN_ONE;
    end
    whole = window >> WINDOW_FRAC_BITS;
    r.whole = ((whole >> OUT_W) != '0) ? WHOLE_MAX : whole[OUT_W-1:0];
    r.ss_flag = ss_on;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t          got;
    result_t          exp;
    logic [CFG_W-1:0] reg_now;
    if (!rst_n) begin
      rtt_limit = TIMEOUT_RESET;
      ss_step = SS_STEP_RESET;
      avoid_num = AV_NUM_RESET;
      window = WIN_RESET;
      loss_thresh = '0;
      loss_cnt = '0;
      ss_on = 1'b1;
      window_updates.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready) begin
        case (reg_idx_t'(cfg_paddr[APB_AW-1:2]))
          REG_TIMEOUT:   reg_now = rtt_limit;
          REG_SS_STEP:   reg_now = ss_step;
          REG_AVOID_NUM: reg_now = avoid_num;
          default:       reg_now = '0;
        endcase
        if (cfg_pwrite) begin
          case (reg_idx_t'(cfg_paddr[APB_AW-1:2]))
            REG_TIMEOUT:   rtt_limit = cfg_pwdata[CFG_W-1:0];
            REG_SS_STEP:   ss_step = cfg_pwdata[CFG_W-1:0];
            REG_AVOID_NUM: avoid_num = cfg_pwdata[CFG_W-1:0];
            default:       ;
          endcase
        end else if (cfg_prdata !== APB_DW'(reg_now)) begin
          report_mismatch($sformatf("register read @%0d got %0h expected %0h",
                                    cfg_paddr, cfg_prdata, reg_now));
        end
      end

      if (out_valid && !out_stall) begin
        got = {out_window_datagrams, out_in_slow_start, out_timeout_seen, out_window_halved};
        if (window_updates.size() == 0) begin
          report_mismatch($sformatf("result transaction with no ack outstanding (%h)", got));
        end else begin
          exp = window_updates.pop_front();
          if (got.whole !== exp.whole) begin
            report_mismatch($sformatf("window_datagrams got %0d expected %0d",
                                      got.whole, exp.whole));
          end
          if (got.ss_flag !== exp.ss_flag) begin
            report_mismatch($sformatf("in_slow_start got %b expected %b",
                                      got.ss_flag, exp.ss_flag));
          end
          if (got.timeout !== exp.timeout) begin
            report_mismatch($sformatf("timeout_seen got %b expected %b",
                                      got.timeout, exp.timeout));
          end
          if (got.halved !== exp.halved) begin
            report_mismatch($sformatf("window_halved got %b expected %b",
                                      got.halved, exp.halved));
          end
        end
      end

      if (in_valid && !in_stall) begin
        window_updates.push_back(advance_window(in_sent_time_ms, in_ack_time_ms));
      end
    end
    pending <= window_updates.size();
    fail_count <= mismatches;
  end

endmodule

>>> bench/tb_ack_driven_congestion_window.sv
`timescale 1ns / 1ps
// testbench top for ack_driven_congestion_window: clock, reset, ack and register
// stimulus with bursty sender and stalling receiver; checking lives in adcw_checker
// depends on adcw_pkg, adcw_checker and the block under test
module tb_ack_driven_congestion_window;
  import adcw_pkg::*;

  localparam int CYCLE_LIMIT  = 500_000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 40;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HALF,
    STALL_HEAVY
  } stall_pattern_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [TIME_W-1:0] in_sent_time_ms = '0;
  logic [TIME_W-1:0] in_ack_time_ms = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [OUT_W-1:0]  out_window_datagrams;
  logic              out_in_slow_start;
  logic              out_timeout_seen;
  logic              out_window_halved;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [APB_AW-1:0] cfg_paddr = '0;
  logic [APB_DW-1:0] cfg_pwdata = '0;
  logic [APB_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  int               fail_count;
  int               pending;
  int               cycle_count = 0;
  int               hold_requests = 0;
  int               burst_left = 0;
  logic             dense = 1'b0;
  logic [CFG_W-1:0] cur_limit = TIMEOUT_RESET;

  ack_driven_congestion_window i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_sent_time_ms      (in_sent_time_ms),
    .in_ack_time_ms       (in_ack_time_ms),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_window_datagrams (out_window_datagrams),
    .out_in_slow_start    (out_in_slow_start),
    .out_timeout_seen     (out_timeout_seen),
    .out_window_halved    (out_window_halved),
    .cfg_psel             (cfg_psel),
    .cfg_penable          (cfg_penable),
    .cfg_pwrite           (cfg_pwrite),
    .cfg_paddr            (cfg_paddr),
    .cfg_pwdata           (cfg_pwdata),
    .cfg_prdata           (cfg_prdata),
    .cfg_pready           (cfg_pready)
  );

  adcw_checker i_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_sent_time_ms      (in_sent_time_ms),
    .in_ack_time_ms       (in_ack_time_ms),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_window_datagrams (out_window_datagrams),
    .out_in_slow_start    (out_in_slow_start),
    .out_timeout_seen     (out_timeout_seen),
    .out_window_halved    (out_window_halved),
    .cfg_psel             (cfg_psel),
    .cfg_penable          (cfg_penable),
    .cfg_pwrite           (cfg_pwrite),
    .cfg_paddr            (cfg_paddr),
    .cfg_pwdata           (cfg_pwdata),
    .cfg_prdata           (cfg_prdata),
    .cfg_pready           (cfg_pready),
    .fail_count           (fail_count),
    .pending              (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver: stall pattern redrawn at random, plus requested hold-offs
  initial begin
    stall_pattern_t pattern;
    int             span;
    int             hold_left;
    int             holds_served;
    pattern = STALL_NONE;
    span = 0;
    hold_left = 0;
    holds_served = 0;
    forever begin
      @(negedge clk);
      if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (span == 0) begin
        pattern = stall_pattern_t'($urandom_range(0, 3));
        span = $urandom_range(64, 256);
      end else begin
        span--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (pattern)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HALF:  out_stall <= 1'($urandom_range(0, 1));
          default:     out_stall <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // one ack transaction; valid stays up across a burst
  task automatic send_ack(input logic [TIME_W-1:0] sent, input logic [TIME_W-1:0] ack);
    @(negedge clk);
    in_valid <= 1'b1;
    in_sent_time_ms <= sent;
    in_ack_time_ms <= ack;
    do @(posedge clk); while (in_stall);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 11);
      if (!dense) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat ($urandom_range(0, 40)) @(negedge clk);
      end
    end
  endtask

  task automatic send_rtt(input logic [TIME_W-1:0] rtt);
    logic [TIME_W-1:0] sent;
    sent = $urandom();
    send_ack(sent, sent + rtt);
  endtask

  function automatic logic [TIME_W-1:0] pick_rtt(input int timeout_pct);
    if ($urandom_range(0, 99) < timeout_pct) begin
      case ($urandom_range(0, 3))
        0:       return TIME_W'(cur_limit) + 1;
        1:       return TIME_W'(cur_limit) + $urandom_range(1, 5000);
        default: return $urandom() | 32'h0001_0000;
      endcase
    end
    case ($urandom_range(0, 3))
      0:       return TIME_W'(cur_limit);
      1:       return '0;
      default: return $urandom_range(0, cur_limit);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_reg_value(input int lo);
    case ($urandom_range(0, 3))
      0:       return CFG_W'(lo);
      1:       return '1;
      2:       return CFG_W'($urandom_range(lo, 300));
      default: return CFG_W'($urandom_range(lo, 65535));
    endcase
  endfunction

  task automatic cfg_access(input logic write, input reg_idx_t idx,
                            input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= write;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= APB_DW'(value);
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (write && idx == REG_TIMEOUT) begin
      cur_limit = value;
    end
  endtask

  task automatic write_config(input logic [CFG_W-1:0] limit, input logic [CFG_W-1:0] step,
                              input logic [CFG_W-1:0] num);
    cfg_access(1'b1, REG_TIMEOUT, limit);
    cfg_access(1'b1, REG_SS_STEP, step);
    cfg_access(1'b1, REG_AVOID_NUM, num);
  endtask

  task automatic read_all_regs();
    cfg_access(1'b0, REG_TIMEOUT, '0);
    cfg_access(1'b0, REG_SS_STEP, '0);
    cfg_access(1'b0, REG_AVOID_NUM, '0);
  endtask

  // let every outstanding ack come back and the block go idle
  task automatic quiesce();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int timeout_pct;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // slow start at reset settings: zero rtt, all-ones times, rtt at the limit, clock wrap
    send_ack('0, '0);
    send_ack('1, '1);
    send_ack(32'h1234_5678, 32'h1234_5678 + TIME_W'(TIMEOUT_RESET));
    send_ack(32'hFFFF_FFF0, 32'h0000_003F);
    read_all_regs();

    quiesce();
    write_config('1, '1, '0);
    send_rtt(32'h0000_FFFF);

    quiesce();
    write_config(CFG_W'($urandom_range(100, 65535)), CFG_W'($urandom_range(0, 511)),
                 CFG_W'($urandom()));
    repeat (30) send_rtt(pick_rtt(0));

    quiesce();
    cfg_access(1'b1, REG_SS_STEP, '0);
    send_rtt('0);
    // first timeout against the zero threshold halves the window
    send_rtt(TIME_W'(cur_limit) + 1);
    quiesce();
    cfg_access(1'b1, REG_AVOID_NUM, '0);
    send_rtt('0);

    quiesce();
    write_config(CFG_W'(1), CFG_W'(1), '1);
    send_rtt(32'd1);
    send_ack(32'd1, 32'd0);
    send_rtt(32'd2);
    // timeouts only: loss counter climbs to the threshold, window halves down to the floor
    repeat (110) send_rtt(pick_rtt(100));
    read_all_regs();

    for (int phase = 0; phase < 7; phase++) begin
      quiesce();
      dense = (phase % 3 == 0);
      write_config(pick_reg_value(1), pick_reg_value(0), pick_reg_value(0));
      cfg_access(1'b0, reg_idx_t'($urandom_range(0, 2)), '0);
      case ($urandom_range(0, 3))
        0:       timeout_pct = 5;
        1:       timeout_pct = 20;
        2:       timeout_pct = 50;
        default: timeout_pct = 90;
      endcase
      if (phase == 2) begin
        hold_requests++;
      end
      repeat (55) send_rtt(pick_rtt(timeout_pct));
    end

    quiesce();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/adcw_pkg.sv
rtl/adcw_rtt_serial.sv
rtl/adcw_div_serial.sv
rtl/adcw_window.sv
rtl/ack_driven_congestion_window.sv
bench/adcw_checker.sv
bench/tb_ack_driven_congestion_window.sv
